[rtl/cbt_pkg.sv]
`timescale 1ns / 1ps
// cbt_pkg: shared types and constants of the cubic bezier tessellator
// no dependencies; imported by every module of the block

package cbt_pkg;

  localparam int STEP_BITS  = 6;
  localparam int SQ_BITS    = 2 * STEP_BITS;
  localparam int COEF_BITS  = 3 * STEP_BITS;
  localparam int NUM_COORDS = 8;

  localparam int ITEM_DEPTH    = 2;
  localparam int ITEM_PTR_BITS = 1;
  localparam int ITEM_CNT_BITS = 2;

  localparam int OUT_DEPTH    = 32;
  localparam int OUT_PTR_BITS = 5;
  localparam int OUT_CNT_BITS = 6;

  localparam logic [1:0] BERN_THREE = 2'd3;

  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEPS_RESET = 6'd32;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic neg_x;
    logic neg_y;
  } div_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
  } pt_ctl_t;

endpackage

[rtl/cbt_front.sv]
`timescale 1ns / 1ps
// cbt_front: step count register, step clamp and the two-entry curve queue
// depends on cbt_pkg

module cbt_front #(
  parameter int COORD_BITS = 16,
  parameter int MAX_STEPS  = 63
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          steps_we,
  input  cbt_pkg::step_t                                steps_wdata,
  input  logic                                          push,
  output logic                                          full,
  input  logic [cbt_pkg::NUM_COORDS-1:0][COORD_BITS-1:0] in_pts,
  input  logic                                          item_pop,
  output logic                                          item_empty,
  output logic [cbt_pkg::NUM_COORDS-1:0][COORD_BITS-1:0] item_pts,
  output cbt_pkg::step_t                                item_steps
);
  import cbt_pkg::*;

  step_t                                  steps_reg;
  step_t                                  steps_eff;
  logic [NUM_COORDS-1:0][COORD_BITS-1:0]  q_pts [ITEM_DEPTH];
  step_t                                  q_steps [ITEM_DEPTH];
  logic [ITEM_PTR_BITS-1:0]               wr_ptr;
  logic [ITEM_PTR_BITS-1:0]               rd_ptr;
  logic [ITEM_CNT_BITS-1:0]               count;
  logic                                   push_fire;
  logic                                   pop_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_reg <= STEPS_RESET;
    end else if (steps_we) begin
      steps_reg <= steps_wdata;
    end
  end

  always_comb begin
    if (steps_reg == '0) begin
      steps_eff = STEP_BITS'(1);
    end else if (steps_reg > STEP_BITS'(MAX_STEPS)) begin
      steps_eff = STEP_BITS'(MAX_STEPS);
    end else begin
      steps_eff = steps_reg;
    end
  end

  assign full       = count == ITEM_CNT_BITS'(ITEM_DEPTH);
  assign item_empty = count == '0;
  assign push_fire  = push && !full;
  assign pop_fire   = item_pop && !item_empty;
  assign item_pts   = q_pts[rd_ptr];
  assign item_steps = q_steps[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + ITEM_CNT_BITS'(push_fire) - ITEM_CNT_BITS'(pop_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      q_pts[wr_ptr]   <= in_pts;
      q_steps[wr_ptr] <= steps_eff;
    end
  end

endmodule

[rtl/cbt_eval.sv]
`timescale 1ns / 1ps
// cbt_eval: point sequencer, bernstein weights, weighted sums and rounding offset
// depends on cbt_pkg; feeds cbt_div

module cbt_eval #(
  parameter int COORD_BITS = 16
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                item_empty,
  output logic                                                item_pop,
  input  logic [cbt_pkg::NUM_COORDS-1:0][COORD_BITS-1:0]       item_pts,
  input  cbt_pkg::step_t                                      item_steps,
  input  logic                                                res_pop,
  output cbt_pkg::div_ctl_t                                   dv_ctl,
  output logic [COORD_BITS+cbt_pkg::COEF_BITS-1:0]            dv_mag_x,
  output logic [COORD_BITS+cbt_pkg::COEF_BITS-1:0]            dv_mag_y,
  output logic [cbt_pkg::COEF_BITS-1:0]                       dv_den
);
  import cbt_pkg::*;

  localparam int PROD_W = COORD_BITS + COEF_BITS + 1;
  localparam int NUM_W  = PROD_W + 2;
  localparam int MAG_W  = COORD_BITS + COEF_BITS;
  localparam int STAGES = 6;

  seq_state_t                             state;
  seq_state_t                             state_next;
  logic [NUM_COORDS-1:0][COORD_BITS-1:0]  cur_pts;
  step_t                                  cur_n;
  step_t                                  step_index;
  logic [OUT_CNT_BITS-1:0]                credit;
  logic                                   issue;
  logic                                   last_issue;

  logic [STAGES-1:0]                      vld;
  logic [STAGES-1:0]                      lst;

  step_t                                  s1_u, s1_j, s1_n;
  logic [NUM_COORDS-1:0][COORD_BITS-1:0]  s1_pts;
  step_t                                  s2_u, s2_j, s2_n;
  logic [SQ_BITS-1:0]                     s2_u2, s2_j2, s2_n2;
  logic [NUM_COORDS-1:0][COORD_BITS-1:0]  s2_pts;
  logic [COEF_BITS-1:0]                   s3_c [4];
  logic [COEF_BITS-1:0]                   s3_den;
  logic [NUM_COORDS-1:0][COORD_BITS-1:0]  s3_pts;
  logic signed [PROD_W-1:0]               s4_px [4];
  logic signed [PROD_W-1:0]               s4_py [4];
  logic [COEF_BITS-1:0]                   s4_den;
  logic signed [NUM_W-1:0]                s5_ax, s5_bx, s5_ay, s5_by;
  logic [COEF_BITS-1:0]                   s5_den;
  logic signed [NUM_W-1:0]                s6_nx, s6_ny;
  logic [COEF_BITS-1:0]                   s6_den;
  logic signed [NUM_W-1:0]                abs_x, abs_y;

  // sequencer
  assign last_issue = step_index == cur_n;

  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (!item_empty) begin
          state_next = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (issue && last_issue) begin
          state_next = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    item_pop = 1'b0;
    issue    = 1'b0;
    unique case (state)
      SEQ_IDLE: item_pop = !item_empty;
      SEQ_RUN:  issue    = credit != OUT_CNT_BITS'(OUT_DEPTH);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SEQ_IDLE;
      step_index <= '0;
      credit     <= '0;
      vld        <= '0;
    end else begin
      state <= state_next;
      if (item_pop) begin
        step_index <= '0;
      end else if (issue) begin
        step_index <= last_issue ? '0 : step_index + 1'b1;
      end
      credit <= credit + OUT_CNT_BITS'(issue) - OUT_CNT_BITS'(res_pop);
      vld    <= {vld[STAGES-2:0], issue};
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      cur_pts <= item_pts;
      cur_n   <= item_steps;
    end
  end

  // arithmetic pipeline
  always_comb begin
    abs_x = s6_nx[NUM_W-1] ? -s6_nx : s6_nx;
    abs_y = s6_ny[NUM_W-1] ? -s6_ny : s6_ny;
  end

  always_ff @(posedge clk) begin
    lst <= {lst[STAGES-2:0], last_issue};

    s1_u   <= cur_n - step_index;
    s1_j   <= step_index;
    s1_n   <= cur_n;
    s1_pts <= cur_pts;

    s2_u   <= s1_u;
    s2_j   <= s1_j;
    s2_n   <= s1_n;
    s2_u2  <= s1_u * s1_u;
    s2_j2  <= s1_j * s1_j;
    s2_n2  <= s1_n * s1_n;
    s2_pts <= s1_pts;

    s3_c[0] <= s2_u2 * s2_u;
    s3_c[1] <= BERN_THREE * s2_u2 * s2_j;
    s3_c[2] <= BERN_THREE * s2_j2 * s2_u;
    s3_c[3] <= s2_j2 * s2_j;
    s3_den  <= s2_n2 * s2_n;
    s3_pts  <= s2_pts;

    for (int i = 0; i < 4; i++) begin
      s4_px[i] <= $signed({1'b0, s3_c[i]}) * $signed(s3_pts[2*i]);
      s4_py[i] <= $signed({1'b0, s3_c[i]}) * $signed(s3_pts[2*i+1]);
    end
    s4_den <= s3_den;

    s5_ax  <= NUM_W'(s4_px[0]) + NUM_W'(s4_px[1]);
    s5_bx  <= NUM_W'(s4_px[2]) + NUM_W'(s4_px[3]);
    s5_ay  <= NUM_W'(s4_py[0]) + NUM_W'(s4_py[1]);
    s5_by  <= NUM_W'(s4_py[2]) + NUM_W'(s4_py[3]);
    s5_den <= s4_den;

    s6_nx  <= s5_ax + s5_bx;
    s6_ny  <= s5_ay + s5_by;
    s6_den <= s5_den;

    // magnitude plus half the denominator, ties away from zero
    dv_mag_x <= MAG_W'(abs_x) + MAG_W'(s6_den >> 1);
    dv_mag_y <= MAG_W'(abs_y) + MAG_W'(s6_den >> 1);
    dv_den   <= s6_den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ctl <= '0;
    end else begin
      dv_ctl.valid <= vld[STAGES-1];
      dv_ctl.last  <= lst[STAGES-1];
      dv_ctl.neg_x <= s6_nx[NUM_W-1];
      dv_ctl.neg_y <= s6_ny[NUM_W-1];
    end
  end

endmodule

[rtl/cbt_div.sv]
`timescale 1ns / 1ps
// cbt_div: pipelined restoring divider, one quotient bit per stage, x and y side by side
// depends on cbt_pkg; sign restore and clamp in the last stage

module cbt_div #(
  parameter int COORD_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  cbt_pkg::div_ctl_t                          in_ctl,
  input  logic [COORD_BITS+cbt_pkg::COEF_BITS-1:0]   in_mag_x,
  input  logic [COORD_BITS+cbt_pkg::COEF_BITS-1:0]   in_mag_y,
  input  logic [cbt_pkg::COEF_BITS-1:0]              in_den,
  output cbt_pkg::pt_ctl_t                           out_ctl,
  output logic [COORD_BITS-1:0]                      out_x,
  output logic [COORD_BITS-1:0]                      out_y
);
  import cbt_pkg::*;

  localparam int MAG_W = COORD_BITS + COEF_BITS;

  div_ctl_t              ctl   [COORD_BITS];
  logic [COORD_BITS-1:0] q_x   [COORD_BITS];
  logic [COORD_BITS-1:0] q_y   [COORD_BITS];
  logic [MAG_W-1:0]      rem_x [COORD_BITS-1];
  logic [MAG_W-1:0]      rem_y [COORD_BITS-1];
  logic [COEF_BITS-1:0]  den   [COORD_BITS-1];

  function automatic logic [COORD_BITS-1:0] restore(input logic [COORD_BITS-1:0] q,
                                                    input logic neg);
    logic [COORD_BITS-1:0] r;
    if (neg) begin
      r = -q;
    end else if (q[COORD_BITS-1]) begin
      r = {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      r = q;
    end
    return r;
  endfunction

  for (genvar k = 0; k < COORD_BITS; k++) begin : g_stage
    localparam int BIT = COORD_BITS - 1 - k;

    div_ctl_t              cin;
    logic [COORD_BITS-1:0] qin_x, qin_y;
    logic [MAG_W-1:0]      rin_x, rin_y;
    logic [COEF_BITS-1:0]  din;
    logic [MAG_W-1:0]      dsh;
    logic                  ge_x, ge_y;

    if (k == 0) begin : g_first
      assign cin   = in_ctl;
      assign qin_x = '0;
      assign qin_y = '0;
      assign rin_x = in_mag_x;
      assign rin_y = in_mag_y;
      assign din   = in_den;
    end else begin : g_next
      assign cin   = ctl[k-1];
      assign qin_x = q_x[k-1];
      assign qin_y = q_y[k-1];
      assign rin_x = rem_x[k-1];
      assign rin_y = rem_y[k-1];
      assign din   = den[k-1];
    end

    assign dsh  = MAG_W'(din) << BIT;
    assign ge_x = rin_x >= dsh;
    assign ge_y = rin_y >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k] <= '0;
      end else begin
        ctl[k] <= cin;
      end
    end

    always_ff @(posedge clk) begin
      q_x[k] <= qin_x | (COORD_BITS'(ge_x) << BIT);
      q_y[k] <= qin_y | (COORD_BITS'(ge_y) << BIT);
    end

    if (k < COORD_BITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_x[k] <= ge_x ? rin_x - dsh : rin_x;
        rem_y[k] <= ge_y ? rin_y - dsh : rin_y;
        den[k]   <= din;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl.valid <= ctl[COORD_BITS-1].valid;
      out_ctl.last  <= ctl[COORD_BITS-1].last;
    end
  end

  always_ff @(posedge clk) begin
    out_x <= restore(q_x[COORD_BITS-1], ctl[COORD_BITS-1].neg_x);
    out_y <= restore(q_y[COORD_BITS-1], ctl[COORD_BITS-1].neg_y);
  end

endmodule

[rtl/cbt_out_fifo.sv]
`timescale 1ns / 1ps
// cbt_out_fifo: result queue with show-ahead read, never overruns thanks to issue credits
// depends on cbt_pkg

module cbt_out_fifo #(
  parameter int COORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cbt_pkg::pt_ctl_t       wr_ctl,
  input  logic [COORD_BITS-1:0]  wr_x,
  input  logic [COORD_BITS-1:0]  wr_y,
  input  logic                   pop,
  output logic                   empty,
  output logic [COORD_BITS-1:0]  rd_x,
  output logic [COORD_BITS-1:0]  rd_y,
  output logic                   rd_last
);
  import cbt_pkg::*;

  logic [COORD_BITS-1:0]   mem_x    [OUT_DEPTH];
  logic [COORD_BITS-1:0]   mem_y    [OUT_DEPTH];
  logic                    mem_last [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] wr_ptr;
  logic [OUT_PTR_BITS-1:0] rd_ptr;
  logic [OUT_CNT_BITS-1:0] count;
  logic                    pop_fire;

  assign empty    = count == '0;
  assign pop_fire = pop && !empty;
  assign rd_x     = mem_x[rd_ptr];
  assign rd_y     = mem_y[rd_ptr];
  assign rd_last  = mem_last[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_ctl.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OUT_CNT_BITS'(wr_ctl.valid) - OUT_CNT_BITS'(pop_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ctl.valid) begin
      mem_x[wr_ptr]    <= wr_x;
      mem_y[wr_ptr]    <= wr_y;
      mem_last[wr_ptr] <= wr_ctl.last;
    end
  end

endmodule

[rtl/cubic_bezier_tessellator_core.sv]
`timescale 1ns / 1ps
// cubic_bezier_tessellator_core: top level of the cubic bezier tessellator
// depends on cbt_pkg, cbt_front, cbt_eval, cbt_div, cbt_out_fifo

// Takes one cubic segment (four Q2.14 control points) per input beat and returns
// steps+1 rounded, clamped Q2.14 points at t = j/steps, the final one flagged by
// last_point. A step count of zero acts as one, values above MAX_STEPS act as
// MAX_STEPS; the count is sampled when a curve is pushed. Up to two curves wait
// in the input queue. The point sequencer loads a curve from that queue and then
// issues one point per cycle while it holds an issue credit; it takes the next
// curve only after the last point of the current one is issued. The arithmetic
// pipeline is followed by the divider, which has one stage per quotient bit;
// issue is held back by credits against the 32-entry result queue, so points
// stop entering the pipeline while 32 are in flight or waiting to be popped.

module cubic_bezier_tessellator_core #(
  parameter int COORD_BITS = 16,
  parameter int MAX_STEPS  = 63
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   steps_per_curve_we,
  input  logic [5:0]             steps_per_curve,
  input  logic                   push,
  output logic                   full,
  input  logic [COORD_BITS-1:0]  start_x,
  input  logic [COORD_BITS-1:0]  start_y,
  input  logic [COORD_BITS-1:0]  pull1_x,
  input  logic [COORD_BITS-1:0]  pull1_y,
  input  logic [COORD_BITS-1:0]  pull2_x,
  input  logic [COORD_BITS-1:0]  pull2_y,
  input  logic [COORD_BITS-1:0]  end_x,
  input  logic [COORD_BITS-1:0]  end_y,
  output logic                   empty,
  input  logic                   pop,
  output logic [COORD_BITS-1:0]  point_x,
  output logic [COORD_BITS-1:0]  point_y,
  output logic                   last_point
);
  import cbt_pkg::*;

  localparam int MAG_W = COORD_BITS + COEF_BITS;

  logic [NUM_COORDS-1:0][COORD_BITS-1:0] in_pts;
  logic [NUM_COORDS-1:0][COORD_BITS-1:0] item_pts;
  step_t                                 item_steps;
  logic                                  item_empty;
  logic                                  item_pop;
  logic                                  pop_fire;
  div_ctl_t                              dv_ctl;
  logic [MAG_W-1:0]                      dv_mag_x;
  logic [MAG_W-1:0]                      dv_mag_y;
  logic [COEF_BITS-1:0]                  dv_den;
  pt_ctl_t                               res_ctl;
  logic [COORD_BITS-1:0]                 res_x;
  logic [COORD_BITS-1:0]                 res_y;

  assign in_pts[0] = start_x;
  assign in_pts[1] = start_y;
  assign in_pts[2] = pull1_x;
  assign in_pts[3] = pull1_y;
  assign in_pts[4] = pull2_x;
  assign in_pts[5] = pull2_y;
  assign in_pts[6] = end_x;
  assign in_pts[7] = end_y;

  assign pop_fire = pop && !empty;

  cbt_front #(
    .COORD_BITS (COORD_BITS),
    .MAX_STEPS  (MAX_STEPS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .steps_we    (steps_per_curve_we),
    .steps_wdata (steps_per_curve),
    .push        (push),
    .full        (full),
    .in_pts      (in_pts),
    .item_pop    (item_pop),
    .item_empty  (item_empty),
    .item_pts    (item_pts),
    .item_steps  (item_steps)
  );

  cbt_eval #(
    .COORD_BITS (COORD_BITS)
  ) u_eval (
    .clk        (clk),
    .rst        (rst),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .item_pts   (item_pts),
    .item_steps (item_steps),
    .res_pop    (pop_fire),
    .dv_ctl     (dv_ctl),
    .dv_mag_x   (dv_mag_x),
    .dv_mag_y   (dv_mag_y),
    .dv_den     (dv_den)
  );

  cbt_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (dv_ctl),
    .in_mag_x (dv_mag_x),
    .in_mag_y (dv_mag_y),
    .in_den   (dv_den),
    .out_ctl  (res_ctl),
    .out_x    (res_x),
    .out_y    (res_y)
  );

  cbt_out_fifo #(
    .COORD_BITS (COORD_BITS)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_ctl  (res_ctl),
    .wr_x    (res_x),
    .wr_y    (res_y),
    .pop     (pop),
    .empty   (empty),
    .rd_x    (point_x),
    .rd_y    (point_y),
    .rd_last (last_point)
  );

endmodule
